// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clk edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clk edge outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/preg_pkg.sv =====
// shared types and constants of the pointer report event generator
`default_nettype none

package preg_pkg;

  localparam int POS_BITS   = 12;
  localparam int BOUND_W    = POS_BITS + 1;
  localparam int MAX_BOUND  = 1 << POS_BITS;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int COORD_W    = 17;
  localparam int DIV_W      = 16;
  // |coord| <= 2^16 times (bound - 1) stays below 2^(16 + POS_BITS)
  localparam int PROD_W     = 16 + POS_BITS;
  localparam int DIV_STEPS  = (PROD_W + 1) / 2;
  localparam int DIVD_W     = 2 * DIV_STEPS;
  localparam int QUOT_W     = DIVD_W + 1;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int DEF_SPAN   = 2047;

  localparam int WIDTH_RST  = 80;
  localparam int HEIGHT_RST = 25;
  localparam int PTR_X_RST  = 40;
  localparam int PTR_Y_RST  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    OP_REL, OP_ABS, OP_SCALED, OP_SET_USB, OP_SET_I2C, OP_REMOVE, OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    DEV_PS2, DEV_USB_MOUSE, DEV_USB_PAD, DEV_I2C_PAD
  } dev_t;

  typedef enum logic [2:0] {
    EV_MOVE, EV_BTN_DOWN, EV_BTN_UP, EV_SCROLL, EV_STATUS
  } ev_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLAMP, ST_DIV_X, ST_DIV_Y, ST_APPLY, ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/preg_in_if.sv =====
// input channel: pointer reports and control operations
`default_nettype none

interface preg_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [1:0]         source_device;
  logic signed [16:0] coord_x;
  logic signed [16:0] coord_y;
  logic signed [16:0] raw_span_x;
  logic signed [16:0] raw_span_y;
  logic [7:0]         button_bits;
  logic signed [7:0]  wheel_step;
  logic               flag_value;

  modport source (
    output valid, opcode, source_device, coord_x, coord_y, raw_span_x, raw_span_y,
           button_bits, wheel_step, flag_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, source_device, coord_x, coord_y, raw_span_x, raw_span_y,
           button_bits, wheel_step, flag_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/preg_out_if.sv =====
// result channel: pointer events and status
`default_nettype none

interface preg_out_if import preg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          event_kind;
  logic [1:0]          event_device;
  logic [POS_BITS-1:0] pos_x;
  logic [POS_BITS-1:0] pos_y;
  logic signed [15:0]  delta_x;
  logic signed [15:0]  delta_y;
  logic signed [7:0]   scroll;
  logic [1:0]          button_index;
  logic [2:0]          button_state;
  logic                last_of_run;

  modport source (
    output valid, event_kind, event_device, pos_x, pos_y, delta_x, delta_y, scroll,
           button_index, button_state, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_device, pos_x, pos_y, delta_x, delta_y, scroll,
           button_index, button_state, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/preg_div.sv =====
// scaling unit: coord * scale / span, signed, truncating, two quotient bits a cycle
`default_nettype none
`include "assert_macros.svh"

module preg_div import preg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] coord,
  input  logic [POS_BITS-1:0]       scale,
  input  logic signed [COORD_W-1:0] span,
  output div_stat_t                 stat,
  output logic signed [QUOT_W-1:0]  quot
);

  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [COORD_W-1:0] coord_mag;
  logic [DIV_W-1:0]   divs;
  logic [DIVD_W-1:0]  prod;
  logic [DIV_W:0]     rs1, rs2;
  logic               ge1, ge2;
  logic [DIV_W-1:0]   rm1, rm2;

  assign coord_mag = coord[COORD_W-1] ? COORD_W'(-coord) : COORD_W'(coord);
  // a span of zero or less means the default full scale
  assign divs = (span[COORD_W-1] || span == '0) ? DIV_W'(DEF_SPAN) : span[DIV_W-1:0];
  assign prod = {{(DIVD_W-COORD_W){1'b0}}, coord_mag}
              * {{(DIVD_W-POS_BITS){1'b0}}, scale};

  // two restoring steps per cycle
  assign rs1 = {rem_r, q_r[DIVD_W-1]};
  assign ge1 = rs1 >= {1'b0, dvs_r};
  assign rm1 = ge1 ? DIV_W'(rs1 - {1'b0, dvs_r}) : rs1[DIV_W-1:0];
  assign rs2 = {rm1, q_r[DIVD_W-2]};
  assign ge2 = rs2 >= {1'b0, dvs_r};
  assign rm2 = ge2 ? DIV_W'(rs2 - {1'b0, dvs_r}) : rs2[DIV_W-1:0];

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      q_nxt   = {q_r[DIVD_W-3:0], ge1, ge2};
      rem_nxt = rm2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      q_nxt    = prod;
      rem_nxt  = '0;
      dvs_nxt  = divs;
      neg_nxt  = coord[COORD_W-1];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  `ASSERT_NEXT(a_done_pulse, done_r, !done_r, "div done held longer than one cycle")
  `ASSERT_NEXT(a_start_runs, start && !busy_r, busy_r, "div start did not begin a run")
  `ASSERT_NEXT(a_run_ends, busy_r && cnt_r == CNT_W'(DIV_STEPS - 1), done_r && !busy_r,
               "div run did not finish on its last step")

endmodule

`default_nettype wire

// ===== hw/rtl/pointer_report_event_generator.sv =====
// Pointer report event generator. Each input beat is a report (relative, absolute or
// scaled absolute) or a control operation (set usb flag, set i2c flag, remove device,
// query). A report clamps and updates the pointer, then sends a move beat (not for a zero
// relative step or an unchanged absolute position), one beat per changed button and a
// scroll beat for a nonzero wheel, with last_of_run on the final one; a ps2 report is
// dropped while a usb or i2c source is on. A query sends one status beat; the other
// operations send nothing. The block takes one item at a time; scaled reports go through
// the shared divider, which resolves 2 quotient bits a cycle for x and then y. A stalled
// receiver adds its wait to every beat; the result register lets the next item enter while
// the last beat still waits. Bounds are written on the cfg port (index 0 width, 1 height);
// a zero write is ignored.
`default_nettype none
`include "assert_macros.svh"

module pointer_report_event_generator import preg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  preg_in_if.sink              in_ch,
  preg_out_if.source           out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  localparam int EVB_MOVE   = 0;
  localparam int EVB_BTN    = 1;
  localparam int EVB_SCROLL = 4;
  localparam int EVB_STATUS = 5;
  localparam int EV_N       = 6;

  // control state
  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    wid_r, wid_nxt;
  logic [CFG_W-1:0]    hgt_r, hgt_nxt;
  logic [POS_BITS-1:0] ptr_x_r, ptr_x_nxt;
  logic [POS_BITS-1:0] ptr_y_r, ptr_y_nxt;
  logic [2:0]          btn_r, btn_nxt;
  logic                usb_r, usb_nxt;
  logic                i2c_r, i2c_nxt;
  logic [1:0]          act_r, act_nxt;
  logic [EV_N-1:0]     pend_r, pend_nxt;
  logic                ov_r, ov_nxt;

  // item payload
  logic [2:0]                op_r, op_nxt;
  logic [1:0]                dev_r, dev_nxt;
  logic signed [COORD_W-1:0] cx_r, cx_nxt;
  logic signed [COORD_W-1:0] cy_r, cy_nxt;
  logic signed [COORD_W-1:0] spx_r, spx_nxt;
  logic signed [COORD_W-1:0] spy_r, spy_nxt;
  logic [2:0]                ibtn_r, ibtn_nxt;
  logic signed [7:0]         wheel_r, wheel_nxt;
  logic                      flag_r, flag_nxt;
  logic signed [15:0]        dx_r, dx_nxt;
  logic signed [15:0]        dy_r, dy_nxt;

  // result register
  logic [2:0]          okind_r, okind_nxt;
  logic [1:0]          odev_r, odev_nxt;
  logic [POS_BITS-1:0] opx_r, opx_nxt;
  logic [POS_BITS-1:0] opy_r, opy_nxt;
  logic signed [15:0]  odx_r, odx_nxt;
  logic signed [15:0]  ody_r, ody_nxt;
  logic signed [7:0]   oscr_r, oscr_nxt;
  logic [1:0]          obidx_r, obidx_nxt;
  logic [2:0]          obst_r, obst_nxt;
  logic                olast_r, olast_nxt;

  logic [BOUND_W-1:0]        w_bnd, h_bnd;
  logic [POS_BITS-1:0]       scale_x, scale_y;
  logic                      div_start;
  logic signed [COORD_W-1:0] div_coord, div_span;
  logic [POS_BITS-1:0]       div_scale;
  div_stat_t                 div_stat;
  logic signed [QUOT_W-1:0]  div_quot;

  logic                      out_free;
  logic                      usb_rm, i2c_rm;
  logic                      rel;
  logic signed [QUOT_W-1:0]  sum_x, sum_y;
  logic [POS_BITS-1:0]       nx, ny;
  logic signed [POS_BITS:0]  adx, ady;
  logic                      mv;
  logic [EV_N-1:0]           sel, rest;

  function automatic logic [POS_BITS-1:0] clamp_pos(input logic signed [QUOT_W-1:0] v,
                                                    input logic [BOUND_W-1:0] bnd);
    logic signed [QUOT_W-1:0] lim;
    lim = $signed(QUOT_W'(bnd));
    if (v < 0) begin
      clamp_pos = '0;
    end else if (v >= lim) begin
      clamp_pos = POS_BITS'(bnd - 1'b1);
    end else begin
      clamp_pos = v[POS_BITS-1:0];
    end
  endfunction

  function automatic logic [1:0] pick_active(input logic usb, input logic i2c);
    if (usb) begin
      pick_active = DEV_USB_MOUSE;
    end else if (i2c) begin
      pick_active = DEV_I2C_PAD;
    end else begin
      pick_active = DEV_PS2;
    end
  endfunction

  assign w_bnd   = (int'(wid_r) > MAX_BOUND) ? BOUND_W'(MAX_BOUND) : BOUND_W'(wid_r);
  assign h_bnd   = (int'(hgt_r) > MAX_BOUND) ? BOUND_W'(MAX_BOUND) : BOUND_W'(hgt_r);
  assign scale_x = (w_bnd > BOUND_W'(1)) ? POS_BITS'(w_bnd - 1'b1) : POS_BITS'(1);
  assign scale_y = (h_bnd > BOUND_W'(1)) ? POS_BITS'(h_bnd - 1'b1) : POS_BITS'(1);

  // x goes to the divider from the clamp cycle, y when x comes back
  assign div_coord = (state_r == ST_CLAMP) ? cx_r : cy_r;
  assign div_span  = (state_r == ST_CLAMP) ? spx_r : spy_r;
  assign div_scale = (state_r == ST_CLAMP) ? scale_x : scale_y;

  preg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .coord (div_coord),
    .scale (div_scale),
    .span  (div_span),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  assign out_free = !ov_r || out_ch.ready;
  assign usb_rm   = (dev_r == DEV_USB_MOUSE || dev_r == DEV_USB_PAD) ? 1'b0 : usb_r;
  assign i2c_rm   = (dev_r == DEV_I2C_PAD) ? 1'b0 : i2c_r;
  assign rel      = (op_r == OP_REL);
  assign sum_x    = $signed(QUOT_W'(ptr_x_r)) + QUOT_W'(cx_r);
  assign sum_y    = $signed(QUOT_W'(ptr_y_r)) + QUOT_W'(cy_r);
  assign nx       = rel ? clamp_pos(sum_x, w_bnd) : clamp_pos(QUOT_W'(cx_r), w_bnd);
  assign ny       = rel ? clamp_pos(sum_y, h_bnd) : clamp_pos(QUOT_W'(cy_r), h_bnd);
  assign adx      = $signed({1'b0, nx}) - $signed({1'b0, ptr_x_r});
  assign ady      = $signed({1'b0, ny}) - $signed({1'b0, ptr_y_r});
  assign mv       = rel ? (cx_r != '0 || cy_r != '0) : (nx != ptr_x_r || ny != ptr_y_r);
  // lowest pending event goes out first
  assign sel      = pend_r & (-pend_r);
  assign rest     = pend_r & ~sel;

  always_comb begin
    state_nxt = state_r;
    wid_nxt   = wid_r;
    hgt_nxt   = hgt_r;
    ptr_x_nxt = ptr_x_r;
    ptr_y_nxt = ptr_y_r;
    btn_nxt   = btn_r;
    usb_nxt   = usb_r;
    i2c_nxt   = i2c_r;
    act_nxt   = act_r;
    pend_nxt  = pend_r;
    ov_nxt    = ov_r;
    op_nxt    = op_r;
    dev_nxt   = dev_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    spx_nxt   = spx_r;
    spy_nxt   = spy_r;
    ibtn_nxt  = ibtn_r;
    wheel_nxt = wheel_r;
    flag_nxt  = flag_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    okind_nxt = okind_r;
    odev_nxt  = odev_r;
    opx_nxt   = opx_r;
    opy_nxt   = opy_r;
    odx_nxt   = odx_r;
    ody_nxt   = ody_r;
    oscr_nxt  = oscr_r;
    obidx_nxt = obidx_r;
    obst_nxt  = obst_r;
    olast_nxt = olast_r;
    div_start = 1'b0;
    in_ch.ready = 1'b0;

    if (cfg_wr_en && cfg_wr_data != '0) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  wid_nxt = cfg_wr_data;
        REG_SCREEN_HEIGHT: hgt_nxt = cfg_wr_data;
        default:           wid_nxt = wid_r;
      endcase
    end

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          dev_nxt   = in_ch.source_device;
          cx_nxt    = in_ch.coord_x;
          cy_nxt    = in_ch.coord_y;
          spx_nxt   = in_ch.raw_span_x;
          spy_nxt   = in_ch.raw_span_y;
          ibtn_nxt  = in_ch.button_bits[2:0];
          wheel_nxt = in_ch.wheel_step;
          flag_nxt  = in_ch.flag_value;
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        ptr_x_nxt = clamp_pos(QUOT_W'(ptr_x_r), w_bnd);
        ptr_y_nxt = clamp_pos(QUOT_W'(ptr_y_r), h_bnd);
        state_nxt = ST_IDLE;
        case (op_r)
          OP_REL, OP_ABS: state_nxt = ST_APPLY;
          OP_SCALED: begin
            div_start = 1'b1;
            state_nxt = ST_DIV_X;
          end
          OP_SET_USB: begin
            usb_nxt = flag_r;
            act_nxt = pick_active(flag_r, i2c_r);
          end
          OP_SET_I2C: begin
            i2c_nxt = flag_r;
            act_nxt = pick_active(usb_r, flag_r);
          end
          OP_REMOVE: begin
            usb_nxt = usb_rm;
            i2c_nxt = i2c_rm;
            if (act_r == dev_r) begin
              act_nxt = pick_active(usb_rm, i2c_rm);
              btn_nxt = '0;
            end
          end
          OP_QUERY: begin
            pend_nxt  = EV_N'(1) << EVB_STATUS;
            state_nxt = ST_EMIT;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DIV_X: begin
        if (div_stat.done) begin
          cx_nxt    = COORD_W'(clamp_pos(div_quot, w_bnd));
          div_start = 1'b1;
          state_nxt = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_stat.done) begin
          cy_nxt    = COORD_W'(clamp_pos(div_quot, h_bnd));
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (dev_r == DEV_PS2 && (usb_r || i2c_r)) begin
          // lower-priority source: drop the report
          state_nxt = ST_IDLE;
        end else begin
          if (dev_r == DEV_USB_MOUSE || dev_r == DEV_USB_PAD) begin
            usb_nxt = 1'b1;
            act_nxt = dev_r;
          end else if (dev_r == DEV_I2C_PAD) begin
            i2c_nxt = 1'b1;
            if (!usb_r) begin
              act_nxt = DEV_I2C_PAD;
            end
          end else begin
            act_nxt = DEV_PS2;
          end
          ptr_x_nxt = nx;
          ptr_y_nxt = ny;
          btn_nxt   = ibtn_r;
          dx_nxt    = rel ? cx_r[15:0] : 16'(adx);
          dy_nxt    = rel ? cy_r[15:0] : 16'(ady);
          pend_nxt  = {1'b0, wheel_r != '0, btn_r ^ ibtn_r, mv};
          state_nxt = ({wheel_r != '0, btn_r ^ ibtn_r, mv} != '0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          odev_nxt  = sel[EVB_STATUS] ? act_r : dev_r;
          opx_nxt   = ptr_x_r;
          opy_nxt   = ptr_y_r;
          obst_nxt  = btn_r;
          odx_nxt   = sel[EVB_MOVE] ? dx_r : '0;
          ody_nxt   = sel[EVB_MOVE] ? dy_r : '0;
          oscr_nxt  = sel[EVB_SCROLL] ? wheel_r : '0;
          obidx_nxt = sel[EVB_BTN + 1] ? 2'd1 : (sel[EVB_BTN + 2] ? 2'd2 : 2'd0);
          if (sel[EVB_MOVE]) begin
            okind_nxt = EV_MOVE;
          end else if (sel[EVB_SCROLL]) begin
            okind_nxt = EV_SCROLL;
          end else if (sel[EVB_STATUS]) begin
            okind_nxt = EV_STATUS;
          end else if ((sel[EVB_BTN+2:EVB_BTN] & btn_r) != '0) begin
            okind_nxt = EV_BTN_DOWN;
          end else begin
            okind_nxt = EV_BTN_UP;
          end
          olast_nxt = (rest == '0);
          pend_nxt  = rest;
          if (rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wid_r   <= CFG_W'(WIDTH_RST);
      hgt_r   <= CFG_W'(HEIGHT_RST);
      ptr_x_r <= POS_BITS'(PTR_X_RST);
      ptr_y_r <= POS_BITS'(PTR_Y_RST);
      btn_r   <= '0;
      usb_r   <= 1'b0;
      i2c_r   <= 1'b0;
      act_r   <= DEV_PS2;
      pend_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wid_r   <= wid_nxt;
      hgt_r   <= hgt_nxt;
      ptr_x_r <= ptr_x_nxt;
      ptr_y_r <= ptr_y_nxt;
      btn_r   <= btn_nxt;
      usb_r   <= usb_nxt;
      i2c_r   <= i2c_nxt;
      act_r   <= act_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    dev_r   <= dev_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    spx_r   <= spx_nxt;
    spy_r   <= spy_nxt;
    ibtn_r  <= ibtn_nxt;
    wheel_r <= wheel_nxt;
    flag_r  <= flag_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    okind_r <= okind_nxt;
    odev_r  <= odev_nxt;
    opx_r   <= opx_nxt;
    opy_r   <= opy_nxt;
    odx_r   <= odx_nxt;
    ody_r   <= ody_nxt;
    oscr_r  <= oscr_nxt;
    obidx_r <= obidx_nxt;
    obst_r  <= obst_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.event_kind   = okind_r;
  assign out_ch.event_device = odev_r;
  assign out_ch.pos_x        = opx_r;
  assign out_ch.pos_y        = opy_r;
  assign out_ch.delta_x      = odx_r;
  assign out_ch.delta_y      = ody_r;
  assign out_ch.scroll       = oscr_r;
  assign out_ch.button_index = obidx_r;
  assign out_ch.button_state = obst_r;
  assign out_ch.last_of_run  = olast_r;

  `ASSERT_IMPL(a_idle_no_pend, state_r == ST_IDLE, pend_r == '0, "events left pending in idle")
  `ASSERT_IMPL(a_run_stays_emit, ov_r && !olast_r, state_r == ST_EMIT,
               "left the emit state in the middle of a run")
  `ASSERT_IMPL(a_div_start_free, div_start, !div_stat.busy, "divider started while busy")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for the pointer report event generator: directed table, random reports, own predictor
`timescale 1ns / 1ps

module tb_top;
  import preg_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]         opcode;
    dev_t               dev;
    logic signed [16:0] coord_x;
    logic signed [16:0] coord_y;
    logic signed [16:0] span_x;
    logic signed [16:0] span_y;
    logic [7:0]         buttons;
    logic signed [7:0]  wheel;
    logic               flag;
  } ptr_report_t;

  typedef struct packed {
    ev_kind_t            kind;
    dev_t                dev;
    logic [POS_BITS-1:0] px;
    logic [POS_BITS-1:0] py;
    logic signed [15:0]  dx;
    logic signed [15:0]  dy;
    logic signed [7:0]   scroll;
    logic [1:0]          bidx;
    logic [2:0]          bstate;
    logic                last;
  } ptr_event_t;

  typedef struct packed {
    ptr_report_t rep;
    logic        typed;
    ptr_event_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  preg_in_if in_if ();
  preg_out_if out_if ();

  pointer_report_event_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if.sink),
    .out_ch     (out_if.source),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_RST);
  logic [CFG_W-1:0] height_reg = CFG_W'(HEIGHT_RST);
  int   ptr_x = PTR_X_RST;
  int   ptr_y = PTR_Y_RST;
  logic [2:0] held = '0;
  logic usb_on = 1'b0;
  logic i2c_on = 1'b0;
  dev_t active = DEV_PS2;

  ptr_event_t fresh_events[$];
  ptr_event_t pending_events[$];
  dir_row_t   dir_tbl[$];

  int mismatches = 0;
  int idle_pct = 0;
  int hold_reqs = 0;

  function automatic int eff_bound(logic [CFG_W-1:0] r);
    return (r > MAX_BOUND) ? MAX_BOUND : int'(r);
  endfunction

  function automatic int clamp_pos(int v, int lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  function automatic void reselect_source();
    if (usb_on) active = DEV_USB_MOUSE;
    else if (i2c_on) active = DEV_I2C_PAD;
    else active = DEV_PS2;
  endfunction

  function automatic void push_event(ev_kind_t kind, dev_t dev, int dx, int dy, int wheel,
                                     int bidx);
    ptr_event_t e;
    e.kind = kind;
    e.dev = dev;
    e.px = ptr_x[POS_BITS-1:0];
    e.py = ptr_y[POS_BITS-1:0];
    e.dx = dx[15:0];
    e.dy = dy[15:0];
    e.scroll = wheel[7:0];
    e.bidx = bidx[1:0];
    e.bstate = held;
    e.last = 1'b0;
    fresh_events.push_back(e);
  endfunction

  // works out the beats one item causes and moves the predictor state along
  function automatic void predict_events(ptr_report_t r);
    int w, h, cx, cy, sx, sy, dx, dy, ox, oy;
    logic [2:0] prev, btn;
    fresh_events.delete();
    w = eff_bound(width_reg);
    h = eff_bound(height_reg);
    ptr_x = clamp_pos(ptr_x, w);
    ptr_y = clamp_pos(ptr_y, h);
    cx = r.coord_x;
    cy = r.coord_y;
    sx = r.span_x;
    sy = r.span_y;
    btn = r.buttons[2:0];
    case (r.opcode)
      OP_SET_USB: begin
        usb_on = r.flag;
        reselect_source();
      end
      OP_SET_I2C: begin
        i2c_on = r.flag;
        reselect_source();
      end
      OP_REMOVE: begin
        if (r.dev == DEV_USB_MOUSE || r.dev == DEV_USB_PAD) usb_on = 1'b0;
        if (r.dev == DEV_I2C_PAD) i2c_on = 1'b0;
        if (active == r.dev) begin
          reselect_source();
          held = '0;
        end
      end
      OP_QUERY: begin
        push_event(EV_STATUS, active, 0, 0, 0, 0);
      end
      OP_REL, OP_ABS, OP_SCALED: begin
        if (r.opcode == OP_SCALED) begin
          if (sx <= 0) sx = DEF_SPAN;
          if (sy <= 0) sy = DEF_SPAN;
          cx = (cx * (w > 1 ? w - 1 : 1)) / sx;
          cy = (cy * (h > 1 ? h - 1 : 1)) / sy;
        end
        // ps2 loses to any active usb or i2c source
        if (!(r.dev == DEV_PS2 && (usb_on || i2c_on))) begin
          if (r.dev == DEV_USB_MOUSE || r.dev == DEV_USB_PAD) begin
            usb_on = 1'b1;
            active = r.dev;
          end else if (r.dev == DEV_I2C_PAD) begin
            i2c_on = 1'b1;
            if (!usb_on) active = DEV_I2C_PAD;
          end else begin
            active = DEV_PS2;
          end
          prev = held;
          ox = ptr_x;
          oy = ptr_y;
          if (r.opcode == OP_REL) begin
            ptr_x = clamp_pos(ox + cx, w);
            ptr_y = clamp_pos(oy + cy, h);
            dx = cx;
            dy = cy;
          end else begin
            ptr_x = clamp_pos(cx, w);
            ptr_y = clamp_pos(cy, h);
            dx = ptr_x - ox;
            dy = ptr_y - oy;
          end
          held = btn;
          if (dx != 0 || dy != 0) push_event(EV_MOVE, r.dev, dx, dy, 0, 0);
          for (int b = 0; b < 3; b++) begin
            if (prev[b] != btn[b])
              push_event(ev_kind_t'(btn[b] ? EV_BTN_DOWN : EV_BTN_UP), r.dev, 0, 0, 0, b);
          end
          if (r.wheel != 0) push_event(EV_SCROLL, r.dev, 0, 0, r.wheel, 0);
        end
      end
      default: ;
    endcase
    if (fresh_events.size() != 0) fresh_events[fresh_events.size() - 1].last = 1'b1;
  endfunction

  function automatic ptr_report_t mk_rep(logic [2:0] op, dev_t dev, int cx, int cy, int sx,
                                         int sy, logic [7:0] btn, int wheel, logic flag);
    ptr_report_t r;
    r.opcode = op;
    r.dev = dev;
    r.coord_x = cx[16:0];
    r.coord_y = cy[16:0];
    r.span_x = sx[16:0];
    r.span_y = sy[16:0];
    r.buttons = btn;
    r.wheel = wheel[7:0];
    r.flag = flag;
    return r;
  endfunction

  function automatic logic [16:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return 17'($urandom_range(0, 17'h1FFFF));
    return 17'(int'($urandom_range(0, 300)) - 50);
  endfunction

  function automatic ptr_report_t rand_report();
    ptr_report_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.opcode = OP_REL;
    else if (pick < 50) r.opcode = OP_ABS;
    else if (pick < 65) r.opcode = OP_SCALED;
    else if (pick < 72) r.opcode = OP_SET_USB;
    else if (pick < 79) r.opcode = OP_SET_I2C;
    else if (pick < 87) r.opcode = OP_REMOVE;
    else if (pick < 96) r.opcode = OP_QUERY;
    else r.opcode = OP_UNUSED;
    r.dev = dev_t'($urandom_range(0, 3));
    if (r.opcode == OP_REL && $urandom_range(0, 3) != 0) begin
      r.coord_x = 17'(int'($urandom_range(0, 40)) - 20);
      r.coord_y = 17'(int'($urandom_range(0, 40)) - 20);
    end else begin
      r.coord_x = rand_coord();
      r.coord_y = rand_coord();
    end
    r.span_x = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 17'h1FFFF))
                                           : 17'($urandom_range(1, 2047));
    r.span_y = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 17'h1FFFF))
                                           : 17'($urandom_range(1, 2047));
    r.buttons = 8'($urandom_range(0, 255));
    r.wheel = ($urandom_range(0, 1) == 0) ? 8'sd0 : 8'($urandom_range(0, 255));
    r.flag = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // sender: called in the step of a rising edge, returns in the step of the accepting edge
  task automatic send_report(ptr_report_t r, logic typed, ptr_event_t want);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= r.opcode;
    in_if.source_device <= r.dev;
    in_if.coord_x <= r.coord_x;
    in_if.coord_y <= r.coord_y;
    in_if.raw_span_x <= r.span_x;
    in_if.raw_span_y <= r.span_y;
    in_if.button_bits <= r.buttons;
    in_if.wheel_step <= r.wheel;
    in_if.flag_value <= r.flag;
    do @(posedge clk); while (!in_if.ready);
    predict_events(r);
    if (typed) pending_events.push_back(want);
    else foreach (fresh_events[i]) pending_events.push_back(fresh_events[i]);
  endtask

  task automatic write_bound(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= value[CFG_W-1:0];
    @(posedge clk);
    if (value[CFG_W-1:0] != 0) begin
      if (idx == REG_SCREEN_WIDTH) width_reg = value[CFG_W-1:0];
      else height_reg = value[CFG_W-1:0];
    end
  endtask

  task automatic set_bounds(int w, int h);
    write_bound(REG_SCREEN_WIDTH, w);
    write_bound(REG_SCREEN_HEIGHT, h);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // items that cause no beat may still be in flight, so settle before touching the bounds
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    int holds_done;
    stall_left = 0;
    hold_left = 0;
    holds_done = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        hold_left = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        stall_left = $urandom_range(0, 5);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    ptr_event_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", out_if.event_kind);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.kind, out_if.event_kind);
        check_field("event_device", want.dev, out_if.event_device);
        check_field("pos_x", want.px, out_if.pos_x);
        check_field("pos_y", want.py, out_if.pos_y);
        check_field("delta_x", want.dx, out_if.delta_x);
        check_field("delta_y", want.dy, out_if.delta_y);
        check_field("scroll", want.scroll, out_if.scroll);
        check_field("button_index", want.bidx, out_if.button_index);
        check_field("button_state", want.bstate, out_if.button_state);
        check_field("last_of_run", want.last, out_if.last_of_run);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[pointer_report_event_generator] ERROR");
    $finish;
  end

  initial begin
    int phase_w[7];
    int phase_h[7];
    phase_w = '{1, 4096, 8191, 0, 4095, 200, 80};
    phase_h = '{1, 4096, 8191, 0, 2, 30, 25};
    in_if.valid = 1'b0;
    in_if.opcode = OP_QUERY;
    in_if.source_device = DEV_PS2;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.raw_span_x = '0;
    in_if.raw_span_y = '0;
    in_if.button_bits = '0;
    in_if.wheel_step = '0;
    in_if.flag_value = 1'b0;

    // status after reset, extreme deltas, then the feature walk
    dir_tbl.push_back('{mk_rep(OP_QUERY, DEV_PS2, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b1,
      '{EV_STATUS, DEV_PS2, 12'd40, 12'd12, 16'sd0, 16'sd0, 8'sd0, 2'd0, 3'd0, 1'b1}});
    dir_tbl.push_back('{mk_rep(OP_REL, DEV_PS2, 65535, 65535, 0, 0, 8'h00, 0, 1'b0), 1'b1,
      '{EV_MOVE, DEV_PS2, 12'd79, 12'd24, -16'sd1, -16'sd1, 8'sd0, 2'd0, 3'd0, 1'b1}});
    // delta wraps to zero in 16 bits but still counts as a move
    dir_tbl.push_back('{mk_rep(OP_REL, DEV_PS2, -65536, -65536, 0, 0, 8'h00, 0, 1'b0), 1'b1,
      '{EV_MOVE, DEV_PS2, 12'd0, 12'd0, 16'sd0, 16'sd0, 8'sd0, 2'd0, 3'd0, 1'b1}});
    dir_tbl.push_back('{mk_rep(OP_ABS, DEV_PS2, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_REL, DEV_PS2, 5, 3, 0, 0, 8'h07, 127, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_REL, DEV_PS2, 0, 0, 0, 0, 8'hF8, -128, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_ABS, DEV_USB_MOUSE, 100, -5, 0, 0, 8'h02, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_REL, DEV_PS2, 1, 1, 0, 0, 8'h05, 3, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_SCALED, DEV_USB_PAD, 65535, -65536, 0, -1, 8'h00, 0, 1'b0),
      1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_SCALED, DEV_I2C_PAD, 1000, 500, 2000, 1000, 8'h01, -1, 1'b0),
      1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_SCALED, DEV_USB_PAD, -7, 7, 65535, 1, 8'h03, 0, 1'b0),
      1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_QUERY, DEV_PS2, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_SET_USB, DEV_PS2, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_QUERY, DEV_PS2, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_SET_I2C, DEV_PS2, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_SET_USB, DEV_PS2, 0, 0, 0, 0, 8'h00, 0, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_REMOVE, DEV_USB_MOUSE, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_SET_I2C, DEV_PS2, 0, 0, 0, 0, 8'h00, 0, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_REMOVE, DEV_I2C_PAD, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_REL, DEV_PS2, -3, 4, 0, 0, 8'h06, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_REMOVE, DEV_PS2, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_UNUSED, DEV_USB_PAD, 9, 9, 0, 0, 8'hFF, 5, 1'b1), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_ABS, DEV_I2C_PAD, 65535, 65535, 0, 0, 8'h05, 1, 1'b0),
      1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_REMOVE, DEV_USB_PAD, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});
    dir_tbl.push_back('{mk_rep(OP_QUERY, DEV_I2C_PAD, 0, 0, 0, 0, 8'h00, 0, 1'b0), 1'b0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 20;
    foreach (dir_tbl[i]) send_report(dir_tbl[i].rep, dir_tbl[i].typed, dir_tbl[i].want);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      set_bounds(phase_w[p], phase_h[p]);
      // odd phases run without gaps, the last one too
      idle_pct = (p == 6 || p % 2 == 1) ? 0 : 25;
      if (p == 5) hold_reqs++;
      for (int n = 0; n < 51; n++) send_report(rand_report(), 1'b0, '0);
      wait_idle();
    end

    for (int i = 0; i < DRAIN_LIMIT && pending_events.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d expected beats never arrived", pending_events.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[pointer_report_event_generator] OK");
    end else begin
      $display("[pointer_report_event_generator] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/preg_pkg.sv
hw/rtl/preg_in_if.sv
hw/rtl/preg_out_if.sv
hw/rtl/preg_div.sv
hw/rtl/pointer_report_event_generator.sv
sim/tb_top.sv
